[rtl/lifo_stack_with_search_defines.svh]
// Assertion macros used by the stack top level.
`ifndef LIFO_STACK_WITH_SEARCH_DEFINES_SVH
`define LIFO_STACK_WITH_SEARCH_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define LSS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lss: same-cycle check failed");
// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define LSS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lss: next-cycle check failed");
`else
`define LSS_ASSERT_IMP(label, ante, cons)
`define LSS_ASSERT_NXT(label, ante, cons)
`endif
`endif

[rtl/lss_pkg.sv]
// Package: constants, codes and controller/datapath types for the LIFO stack.
`timescale 1ns / 1ps
package lss_pkg;

    localparam int DEPTH   = 8;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 2;
    localparam int ECNT_W  = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_SEARCH = 3'd2,
        CMD_SIZE   = 3'd3,
        CMD_DUMP   = 3'd4,
        CMD_PEEK   = 3'd5
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } t_status;

    // Read address source for the entry memory.
    typedef enum logic [2:0] {
        RD_NONE = 3'd0,
        RD_TOP  = 3'd1,
        RD_ZERO = 3'd2,
        RD_UP   = 3'd3,
        RD_DOWN = 3'd4
    } t_rd_sel;

    // What the result register takes when loaded.
    typedef enum logic [1:0] {
        RES_PLAIN = 2'd0,
        RES_DATA  = 2'd1,
        RES_FOUND = 2'd2
    } t_res_sel;

    typedef struct packed {
        logic     cap_opnd;
        logic     push_wr;
        logic     pop_dec;
        t_rd_sel  rd_sel;
        logic     hit_clr;
        logic     hit_acc;
        logic     out_ld;
        t_status  out_status;
        t_res_sel out_sel;
        logic     out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic idx_end;
        logic idx_zero;
        logic out_last;
    } t_dp_sts;

endpackage

[rtl/lss_in_if.sv]
// Command channel interface: valid/ready plus command and operand.
`timescale 1ns / 1ps
interface lss_in_if;
    logic                              valid;
    logic                              ready;
    logic [lss_pkg::CMD_W-1:0]         command;
    logic signed [lss_pkg::DATA_W-1:0] operand_value;

    modport source (output valid, output command, output operand_value, input ready);
    modport sink   (input valid, input command, input operand_value, output ready);
endinterface

[rtl/lss_out_if.sv]
// Result channel interface: valid/ready plus result fields.
`timescale 1ns / 1ps
interface lss_out_if;
    logic                              valid;
    logic                              ready;
    logic [lss_pkg::STAT_W-1:0]        status;
    logic signed [lss_pkg::DATA_W-1:0] result_value;
    logic                              found;
    logic [lss_pkg::ECNT_W-1:0]        entry_count;
    logic                              last;

    modport source (output valid, output status, output result_value, output found,
                    output entry_count, output last, input ready);
    modport sink   (input valid, input status, input result_value, input found,
                    input entry_count, input last, output ready);
endinterface

[rtl/lifo_stack_with_search.sv]
// Top level: bounded LIFO stack of signed 32-bit values with search and dump.
// Commands are handled one at a time: pop/peek and dump go through the registered memory
// read, and search scans every held entry. The next command transfer is taken the cycle
// after the final result transfer.
// Reset: synchronous active-low clears the count and the controller; entries keep junk.
`timescale 1ns / 1ps
`include "lifo_stack_with_search_defines.svh"
module lifo_stack_with_search (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lss_in_if.sink     i_in,
    lss_out_if.source  o_out
);

    // Control/status bundle between the sequencer and the datapath.
    lss_pkg::t_dp_cmd w_cmd;
    lss_pkg::t_dp_sts w_sts;

    // Controller: one-hot FSM. Idle is the only state that takes an input transfer;
    // the result is held in the datapath's output register until the sink takes it.
    lss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_command   (i_in.command),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (w_cmd)
    );

    // Datapath: entry memory (one write, one registered read per cycle), entry
    // count, scan index for search and dump, match accumulator, result register.
    lss_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_operand      (i_in.operand_value),
        .o_sts          (w_sts),
        .o_status       (o_out.status),
        .o_result_value (o_out.result_value),
        .o_found        (o_out.found),
        .o_entry_count  (o_out.entry_count),
        .o_last         (o_out.last)
    );

    // A result waiting means no new command is taken.
    `LSS_ASSERT_IMP(a_no_overlap, o_out.valid, !i_in.ready)
    // Mid-dump transfer: the block keeps reading entries instead of going idle.
    `LSS_ASSERT_NXT(a_dump_continues, o_out.valid && o_out.ready && !o_out.last, !i_in.ready)
    // An overflow refusal is only reported while the stack really is full.
    `LSS_ASSERT_IMP(a_ovf_when_full, o_out.valid && o_out.status == lss_pkg::ST_OVERFLOW,
                    w_sts.full)
    // Only dump produces non-final results, and those always carry ok status.
    `LSS_ASSERT_IMP(a_multi_ok, o_out.valid && !o_out.last, o_out.status == lss_pkg::ST_OK)

endmodule

[rtl/lss_ctrl.sv]
// Controller: sequences each command and drives the datapath.
`timescale 1ns / 1ps
module lss_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [lss_pkg::CMD_W-1:0] i_command,
    input  logic                      i_out_ready,
    input  lss_pkg::t_dp_sts          i_sts,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    output lss_pkg::t_dp_cmd          o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_SRCH = 5'b00100,
        S_DUMP = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap_opnd   = 1'b1;
                    o_cmd.out_status = lss_pkg::ST_OK;
                    o_cmd.out_sel    = lss_pkg::RES_PLAIN;
                    o_cmd.out_last   = 1'b1;
                    case (lss_pkg::t_cmd'(i_command))
                        lss_pkg::CMD_PUSH: begin
                            o_cmd.out_ld = 1'b1;
                            if (i_sts.full) begin
                                o_cmd.out_status = lss_pkg::ST_OVERFLOW;
                            end else begin
                                o_cmd.push_wr = 1'b1;
                            end
                            n_state = S_OUT;
                        end
                        lss_pkg::CMD_POP, lss_pkg::CMD_PEEK: begin
                            if (i_sts.empty) begin
                                o_cmd.out_ld     = 1'b1;
                                o_cmd.out_status = lss_pkg::ST_EMPTY;
                                n_state          = S_OUT;
                            end else begin
                                o_cmd.pop_dec = (i_command == lss_pkg::CMD_POP);
                                o_cmd.rd_sel  = lss_pkg::RD_TOP;
                                n_state       = S_READ;
                            end
                        end
                        lss_pkg::CMD_SEARCH: begin
                            if (i_sts.empty) begin
                                o_cmd.out_ld = 1'b1;
                                n_state      = S_OUT;
                            end else begin
                                o_cmd.hit_clr = 1'b1;
                                o_cmd.rd_sel  = lss_pkg::RD_ZERO;
                                n_state       = S_SRCH;
                            end
                        end
                        lss_pkg::CMD_SIZE: begin
                            o_cmd.out_ld = 1'b1;
                            n_state      = S_OUT;
                        end
                        lss_pkg::CMD_DUMP: begin
                            if (i_sts.empty) begin
                                o_cmd.out_ld     = 1'b1;
                                o_cmd.out_status = lss_pkg::ST_EMPTY;
                                n_state          = S_OUT;
                            end else begin
                                o_cmd.rd_sel = lss_pkg::RD_TOP;
                                n_state      = S_DUMP;
                            end
                        end
                        default: begin
                            // unused codes: dropped, nothing returned
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ: begin
                o_cmd.out_ld   = 1'b1;
                o_cmd.out_sel  = lss_pkg::RES_DATA;
                o_cmd.out_last = 1'b1;
                n_state        = S_OUT;
            end
            S_SRCH: begin
                if (i_sts.idx_end) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_sel  = lss_pkg::RES_FOUND;
                    o_cmd.out_last = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.hit_acc = 1'b1;
                    o_cmd.rd_sel  = lss_pkg::RD_UP;
                end
            end
            S_DUMP: begin
                o_cmd.out_ld   = 1'b1;
                o_cmd.out_sel  = lss_pkg::RES_DATA;
                o_cmd.out_last = i_sts.idx_zero;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (i_sts.out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.rd_sel = lss_pkg::RD_DOWN;
                        n_state      = S_DUMP;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/lss_datapath.sv]
// Datapath: entry memory, count, index, search match and result register.
`timescale 1ns / 1ps
module lss_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lss_pkg::t_dp_cmd                  i_cmd,
    input  logic signed [lss_pkg::DATA_W-1:0] i_operand,
    output lss_pkg::t_dp_sts                  o_sts,
    output logic [lss_pkg::STAT_W-1:0]        o_status,
    output logic signed [lss_pkg::DATA_W-1:0] o_result_value,
    output logic                              o_found,
    output logic [lss_pkg::ECNT_W-1:0]        o_entry_count,
    output logic                              o_last
);

    logic [lss_pkg::DATA_W-1:0] r_mem [lss_pkg::DEPTH];
    logic [lss_pkg::DATA_W-1:0] r_rdata;

    logic [lss_pkg::CNT_W-1:0]  r_count;
    logic [lss_pkg::CNT_W-1:0]  n_count;
    logic [lss_pkg::CNT_W-1:0]  w_cnt_m1;
    logic [lss_pkg::IDX_W-1:0]  r_idx;
    logic [lss_pkg::IDX_W-1:0]  n_idx;
    logic                       w_rd_en;

    logic [lss_pkg::DATA_W-1:0] r_opnd;
    logic                       r_hit;
    logic                       w_eq;

    logic [lss_pkg::STAT_W-1:0] r_status;
    logic [lss_pkg::DATA_W-1:0] r_value;
    logic                       r_found;
    logic [lss_pkg::ECNT_W-1:0] r_ecount;
    logic                       r_last;

    assign w_cnt_m1 = r_count - lss_pkg::CNT_W'(1);

    always_comb begin
        n_count = r_count;
        if (i_cmd.push_wr) begin
            n_count = r_count + lss_pkg::CNT_W'(1);
        end else if (i_cmd.pop_dec) begin
            n_count = w_cnt_m1;
        end
    end

    always_comb begin
        n_idx   = r_idx;
        w_rd_en = 1'b1;
        case (i_cmd.rd_sel)
            lss_pkg::RD_TOP:  n_idx = w_cnt_m1[lss_pkg::IDX_W-1:0];
            lss_pkg::RD_ZERO: n_idx = '0;
            lss_pkg::RD_UP:   n_idx = r_idx + lss_pkg::IDX_W'(1);
            lss_pkg::RD_DOWN: n_idx = r_idx - lss_pkg::IDX_W'(1);
            default:          w_rd_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // single write port, single registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_wr) begin
            r_mem[r_count[lss_pkg::IDX_W-1:0]] <= i_operand;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[n_idx];
        end
    end

    assign w_eq = (r_rdata == r_opnd);

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.cap_opnd) begin
            r_opnd <= i_operand;
        end
        if (i_cmd.hit_clr) begin
            r_hit <= 1'b0;
        end else if (i_cmd.hit_acc) begin
            r_hit <= r_hit | w_eq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_status <= i_cmd.out_status;
            r_value  <= (i_cmd.out_sel == lss_pkg::RES_DATA) ? r_rdata : '0;
            r_found  <= (i_cmd.out_sel == lss_pkg::RES_FOUND) ? (r_hit | w_eq) : 1'b0;
            r_ecount <= lss_pkg::ECNT_W'(n_count);
            r_last   <= i_cmd.out_last;
        end
    end

    assign o_sts.empty    = (r_count == '0);
    assign o_sts.full     = (r_count == lss_pkg::CNT_W'(lss_pkg::DEPTH));
    assign o_sts.idx_end  = (r_idx == w_cnt_m1[lss_pkg::IDX_W-1:0]);
    assign o_sts.idx_zero = (r_idx == '0);
    assign o_sts.out_last = r_last;

    assign o_status       = r_status;
    assign o_result_value = r_value;
    assign o_found        = r_found;
    assign o_entry_count  = r_ecount;
    assign o_last         = r_last;

endmodule
